FILE: design/soc_pkg.sv
// Shared constants and types for the sorted array occurrence counter.
`timescale 1ns / 1ps

package soc_pkg;

    localparam int DEPTH   = 1024;
    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = AW + 1;
    localparam int IW      = AW + 2;
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 11;
    localparam int IDX_W   = 10;
    localparam int OUT_W   = ((OCC_W + IDX_W + 7) / 8) * 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                     we;
        logic [AW-1:0]            addr;
        logic signed [DATA_W-1:0] data;
    } soc_load_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] key;
        logic [LW-1:0]            length;
    } soc_query_t;

    typedef struct packed {
        logic             valid;
        logic [OCC_W-1:0] occurrences;
        logic [IDX_W-1:0] first_index;
    } soc_result_t;

endpackage

FILE: design/soc_search.sv
// Element memory and the two-pass binary search sequencer.
`timescale 1ns / 1ps

module soc_search (
    input  logic                clk,
    input  logic                rst_n,
    input  soc_pkg::soc_load_t  load,
    input  soc_pkg::soc_query_t query,
    input  logic                res_ready,
    output logic                idle,
    output soc_pkg::soc_result_t res
);
    import soc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PROBE = 5'b00010,
        S_CMP   = 5'b00100,
        S_NBR   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]            rd_addr;

    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [LW-1:0]            len_reg, len_next;
    logic signed [IW-1:0]     low_reg, low_next;
    logic signed [IW-1:0]     high_reg, high_next;
    logic [AW-1:0]            mid_reg, mid_next;
    logic [AW-1:0]            first_reg, first_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic                     pass_reg, pass_next;

    logic signed [IW-1:0]     mid_calc;
    logic signed [IW-1:0]     mid_ext;
    logic                     at_edge;
    logic                     found;

    assign mid_calc = low_reg + ((high_reg - low_reg) >>> 1);
    assign mid_ext  = $signed({2'b00, mid_reg});
    // The second pass looks right, so its edge is the last element.
    assign at_edge  = pass_reg ? ({1'b0, mid_reg} == (len_reg - LW'(1)))
                               : (mid_reg == '0);

    always_ff @(posedge clk)
    begin
        if (load.we)
        begin
            mem[load.addr] <= load.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        first_next = first_reg;
        occ_next   = occ_reg;
        pass_next  = pass_reg;
        rd_addr    = mid_calc[AW-1:0];
        found      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (query.start)
                begin
                    key_next   = query.key;
                    len_next   = query.length;
                    low_next   = '0;
                    high_next  = $signed({1'b0, query.length}) - IW'(1);
                    pass_next  = 1'b0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (low_reg > high_reg)
                begin
                    occ_next = '0;
                    if (!pass_reg)
                    begin
                        first_next = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next   = mid_calc[AW-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                rd_addr = pass_reg ? (mid_reg + AW'(1)) : (mid_reg - AW'(1));
                if (rdata_reg == key_reg)
                begin
                    if (at_edge)
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        state_next = S_NBR;
                    end
                end
                else
                begin
                    if (rdata_reg > key_reg)
                    begin
                        high_next = mid_ext - IW'(1);
                    end
                    else
                    begin
                        low_next = mid_ext + IW'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            S_NBR:
            begin
                if (rdata_reg != key_reg)
                begin
                    found = 1'b1;
                end
                else
                begin
                    if (pass_reg)
                    begin
                        low_next = mid_ext + IW'(1);
                    end
                    else
                    begin
                        high_next = mid_ext - IW'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (found)
        begin
            if (!pass_reg)
            begin
                first_next = mid_reg;
                pass_next  = 1'b1;
                low_next   = '0;
                high_next  = $signed({1'b0, len_reg}) - IW'(1);
                state_next = S_PROBE;
            end
            else
            begin
                // An unsorted array can put the last hit before the first.
                if (mid_reg >= first_reg)
                begin
                    occ_next = OCC_W'({1'b0, mid_reg} - {1'b0, first_reg} + LW'(1));
                end
                else
                begin
                    occ_next = '0;
                end
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        len_reg   <= len_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        mid_reg   <= mid_next;
        first_reg <= first_next;
        occ_reg   <= occ_next;
    end

    assign idle            = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_DONE);
    assign res.occurrences = occ_reg;
    assign res.first_index = IDX_W'(first_reg);

endmodule

FILE: design/sorted_array_occurrence_counter.sv
// Top level of the sorted array occurrence counter.
`timescale 1ns / 1ps
//
// The input stream carries one word per item. tuser selects the kind: a load
// appends tdata to the stored array, and a load with tlast set closes the
// array, so that the next load starts a new one at index 0. Loads beyond the
// memory depth are dropped. A query (tuser high) counts the stored elements
// equal to tdata and returns one output word with the count and the index of
// the first match; loads return nothing.
// A load does not hold the input. A query runs two binary searches over the
// element memory: each probe computes the midpoint, reads and compares that
// element, and also checks the neighbor element when it matches and is not at
// the edge; one search makes at most log2(length) + 1 probes. A value that is
// absent needs only the first search. The result then sits in an output
// register.
// While a query runs, s_tready is low; loads are still taken while a result
// waits for m_tready, but a new query cannot finish until that word leaves.
// Reset empties the array and marks it closed; memory contents are not
// cleared, and only entries of the current array are ever compared.

module sorted_array_occurrence_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [soc_pkg::DATA_W-1:0] s_tdata,   // item_value
    input  logic                       s_tuser,   // kind
    input  logic                       s_tlast,   // last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [soc_pkg::OUT_W-1:0]  m_tdata    // occurrences, first_index, zero pad
);
    import soc_pkg::*;

    logic             s_fire;
    logic             load_fire;
    logic             search_idle;
    logic             res_ready;
    logic [LW-1:0]    base;
    logic [LW-1:0]    length_reg, length_next;
    logic             closed_reg, closed_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    soc_load_t        load;
    soc_query_t       query;
    soc_result_t      res;

    assign s_tready  = search_idle;
    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (s_tuser == KIND_LOAD);

    assign base = closed_reg ? '0 : length_reg;

    always_comb
    begin
        load.we   = load_fire && (base < LW'(DEPTH));
        load.addr = base[AW-1:0];
        load.data = $signed(s_tdata);

        query.start  = s_fire && (s_tuser == KIND_QUERY);
        query.key    = $signed(s_tdata);
        query.length = length_reg;

        length_next = length_reg;
        closed_next = closed_reg;
        if (load_fire)
        begin
            length_next = load.we ? (base + LW'(1)) : base;
            closed_next = s_tlast;
        end
    end

    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res.valid || (m_tvalid_reg && !m_tready);

    soc_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .query     (query),
        .res_ready (res_ready),
        .idle      (search_idle),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            closed_reg   <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            closed_reg   <= closed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            m_tdata_reg <= OUT_W'({res.first_index, res.occurrences});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/soc_checker.sv
// Port-level checks for the sorted array occurrence counter, bound to the top level.
`timescale 1ns / 1ps

module soc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [soc_pkg::OUT_W-1:0] m_tdata
);
    import soc_pkg::*;

    // A stalled output word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // The counted run never reaches past the end of the memory.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[OCC_W-1:0]}
                      + {2'b00, m_tdata[OCC_W+IDX_W-1:OCC_W]}) <= (OCC_W + 1)'(DEPTH))
        else $error("occurrence run exceeds the array");

    // A load does not occupy the search, so the input stays open after it.
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> s_tready)
        else $error("input closed after a load");

    // A query keeps the input closed while the search runs.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_QUERY) |=> !s_tready)
        else $error("input open during a search");

endmodule

bind sorted_array_occurrence_counter soc_checker u_soc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
